// File: design/paged_block_table_manager_unit_assert.svh
// Assertion macros used by the port-level checker.
`ifndef PAGED_BLOCK_TABLE_MANAGER_UNIT_ASSERT_SVH
`define PAGED_BLOCK_TABLE_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PBTM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbtm assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PBTM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbtm assertion failed");

`endif

// File: design/pbtm_pkg.sv
// Shared constants, codes and types of the paged block table manager.
package pbtm_pkg;

  localparam int NUM_BLOCKS         = 1024;
  localparam int MAX_SEQS           = 64;
  localparam int MAX_BLOCKS_PER_SEQ = 128;
  localparam int MAX_APPEND         = 64;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int TOP_W   = BLK_W + 1;
  localparam int SLOT_W  = $clog2(MAX_SEQS);
  localparam int BIDX_W  = $clog2(MAX_BLOCKS_PER_SEQ);
  localparam int TBL_AW  = SLOT_W + BIDX_W;
  localparam int CNT_W   = BIDX_W + 1;
  localparam int TOK_W   = $clog2(MAX_APPEND) + 1;
  localparam int LEN_W   = 16;
  localparam int POS_W   = 15;
  localparam int TPB_W   = 9;
  localparam int SIB_W   = 8;
  localparam int DIV_W   = LEN_W + 1;
  localparam int MAX_LEN = 32768;
  localparam int TPB_MIN = 16;
  localparam int TPB_MAX = 256;

  localparam logic [1:0] CFG_TPB  = 2'd0;
  localparam logic [1:0] CFG_POOL = 2'd1;

  typedef enum logic [2:0] {
    OP_REBUILD  = 3'd0,
    OP_CREATE   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_TRUNCATE = 3'd3,
    OP_APPEND   = 3'd4,
    OP_QUERY    = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXCEEDS   = 3'd3,
    ST_NO_BLOCK  = 3'd4,
    ST_BAD_AMT   = 3'd5
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SLOT_RD  = 11'b000_0000_0010,
    S_DECIDE   = 11'b000_0000_0100,
    S_DIV      = 11'b000_0000_1000,
    S_FREE_RD  = 11'b000_0001_0000,
    S_FREE_WR  = 11'b000_0010_0000,
    S_ALLOC_RD = 11'b000_0100_0000,
    S_ALLOC_WR = 11'b000_1000_0000,
    S_TOK_RD   = 11'b001_0000_0000,
    S_TOK_EM   = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lim;
    logic [CNT_W-1:0] cnt;
  } slot_rec_t;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] tp;
    logic [SIB_W-1:0] sib;
    logic [BLK_W-1:0] pb;
    logic [TOP_W-1:0] free;
    logic [LEN_W-1:0] len;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [TPB_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [TPB_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/pbtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pbtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pbtm_div.sv
// Restoring divider, one quotient bit per cycle.
module pbtm_div
  import pbtm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [TPB_W-1:0] rem_q, rem_d;
  logic [TPB_W-1:0] den_q, den_d;
  logic [TPB_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_W);
      num_d  = req_i.dividend;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? TPB_W'(trial - {1'b0, den_q}) : trial[TPB_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      num_d = {num_q[DIV_W-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: design/paged_block_table_manager_unit.sv
// Top level of the paged block table manager.
// One operation is taken at a time; s_axis_tready is high only when the sequencer is idle.
// Query, create, rebuild and the error results decided before any division pass through the
// slot read, decide and emit states from accept to accept. Truncate and append each run the
// shared divider, which forms 17 quotient bits and then the done flag. A successful append
// divides twice: once for the block count, once for the first token's block and offset.
// Remove and truncate free each block with a block table read, then a free stack push;
// append allocates each block with a free stack read, then a block table write, and gives
// each token result with a block table read, then an emit. Each result waits in the output
// register until taken. A rebuild takes effect at once: the free stack contents below a
// low-water mark are generated from the rebuild size, so there is no clearing sweep after
// reset. Entries of the block table read back only below a sequence's block count.
module paged_block_table_manager_unit
  import pbtm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // seq_slot[5:0], amount[21:6], zero pad
  input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // status, length_now, free_blocks, phys_block,
                                      // slot_in_block, token_pos, zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0]  amt_q, amt_d;
  logic [TPB_W-1:0]  tpb_q, tpb_d;
  logic [TPB_W-1:0]  cfg_tpb_q;
  logic [TOP_W-1:0]  cfg_pool_q;
  logic [TOP_W-1:0]  free_top_q, free_top_d;
  logic [TOP_W-1:0]  base_q, base_d;
  logic [TOP_W-1:0]  lw_q, lw_d;
  logic [MAX_SEQS-1:0] valid_q, valid_d;
  logic [LEN_W-1:0]  len_q, len_d, lim_q, lim_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, need_q, need_d, idx_q, idx_d, keep_q, keep_d;
  logic [DIV_W-1:0]  newlen_q, newlen_d;
  logic [BIDX_W-1:0] bi_q, bi_d;
  logic [SIB_W-1:0]  off_q, off_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [TOK_W-1:0]  tok_q, tok_d;
  logic              pos_phase_q, pos_phase_d;
  result_t           res_q, res_d;
  logic              m_valid_q, m_valid_d;
  result_t           m_res_q, m_res_d;

  logic              slot_we;
  slot_rec_t         slot_wdata, slot_rdata, slot_rec;
  logic              stk_we;
  logic [BLK_W-1:0]  stk_waddr, stk_wdata, stk_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [BLK_W-1:0]  tbl_wdata, tbl_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              out_free;
  logic [TOP_W-1:0]  pidx;
  logic [TPB_W-1:0]  tpb_mask;
  logic [DIV_W:0]    need_full;
  logic [TOK_W-1:0]  tok_last;

  function automatic result_t mk_res(status_e st, logic [LEN_W-1:0] len);
    result_t r;
    r        = '0;
    r.status = st;
    r.len    = len;
    r.last   = 1'b1;
    return r;
  endfunction

  pbtm_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(MAX_SEQS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_q),
    .wdata_i (slot_wdata),
    .raddr_i (slot_q),
    .rdata_o (slot_rdata)
  );

  pbtm_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (pidx[BLK_W-1:0]),
    .rdata_o (stk_rdata)
  );

  pbtm_ram #(.WIDTH(BLK_W), .DEPTH(MAX_SEQS * MAX_BLOCKS_PER_SEQ)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  pbtm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free  = !m_valid_q || m_axis_tready;
  assign pidx      = free_top_q - TOP_W'(1);
  assign slot_rec  = valid_q[slot_q] ? slot_rdata : '0;
  assign tpb_mask  = cfg_tpb_q & TPB_W'(9'h1F0);
  assign need_full = {1'b0, div_rsp.quot} + (DIV_W+1)'(div_rsp.rem != '0);
  assign tok_last  = amt_q[TOK_W-1:0] - TOK_W'(1);
  assign tbl_raddr = {slot_q, (state_q == S_FREE_RD) ? idx_q[BIDX_W-1:0] : bi_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    slot_d      = slot_q;
    amt_d       = amt_q;
    tpb_d       = tpb_q;
    free_top_d  = free_top_q;
    base_d      = base_q;
    lw_d        = lw_q;
    valid_d     = valid_q;
    len_d       = len_q;
    lim_d       = lim_q;
    cnt_d       = cnt_q;
    need_d      = need_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    newlen_d    = newlen_q;
    bi_d        = bi_q;
    off_d       = off_q;
    pos_d       = pos_q;
    tok_d       = tok_q;
    pos_phase_d = pos_phase_q;
    res_d       = res_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_res_d     = m_res_q;
    slot_we     = 1'b0;
    slot_wdata  = '0;
    stk_we      = 1'b0;
    stk_waddr   = free_top_q[BLK_W-1:0];
    stk_wdata   = tbl_rdata;
    tbl_we      = 1'b0;
    tbl_waddr   = {slot_q, cnt_q[BIDX_W-1:0]};
    tbl_wdata   = stk_rdata;
    div_req     = '0;
    div_req.divisor = tpb_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d   = s_axis_tuser;
          slot_d = s_axis_tdata[SLOT_W-1:0];
          amt_d  = s_axis_tdata[SLOT_W +: LEN_W];
          if (tpb_mask == '0) begin
            tpb_d = TPB_W'(TPB_MIN);
          end else if (tpb_mask > TPB_W'(TPB_MAX)) begin
            tpb_d = TPB_W'(TPB_MAX);
          end else begin
            tpb_d = tpb_mask;
          end
          state_d = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        len_d   = slot_rec.len;
        lim_d   = slot_rec.lim;
        cnt_d   = slot_rec.cnt;
        state_d = S_EMIT;
        case (op_q)
          OP_REBUILD: begin
            free_top_d = (cfg_pool_q > TOP_W'(NUM_BLOCKS)) ? TOP_W'(NUM_BLOCKS) : cfg_pool_q;
            base_d     = free_top_d;
            lw_d       = free_top_d;
            valid_d    = '0;
            res_d      = mk_res(ST_OK, '0);
          end
          OP_CREATE: begin
            if (slot_rec.used) begin
              res_d = mk_res(ST_EXISTS, slot_rec.len);
            end else if (amt_q > LEN_W'(MAX_LEN)) begin
              res_d = mk_res(ST_BAD_AMT, '0);
            end else begin
              slot_we          = 1'b1;
              slot_wdata.used  = 1'b1;
              slot_wdata.lim   = amt_q;
              valid_d[slot_q]  = 1'b1;
              res_d            = mk_res(ST_OK, '0);
            end
          end
          OP_REMOVE, OP_TRUNCATE, OP_APPEND, OP_QUERY: begin
            if (!slot_rec.used) begin
              res_d = mk_res(ST_NOT_FOUND, '0);
            end else if (op_q == OP_REMOVE) begin
              idx_d   = '0;
              state_d = S_FREE_RD;
            end else if (op_q == OP_TRUNCATE) begin
              if (amt_q > slot_rec.len) begin
                res_d = mk_res(ST_EXCEEDS, slot_rec.len);
              end else begin
                newlen_d         = DIV_W'(slot_rec.len - amt_q);
                div_req.start    = 1'b1;
                div_req.dividend = newlen_d;
                pos_phase_d      = 1'b0;
                state_d          = S_DIV;
              end
            end else if (op_q == OP_QUERY) begin
              res_d = mk_res(ST_OK, slot_rec.len);
            end else if (amt_q == '0) begin
              res_d = mk_res(ST_OK, slot_rec.len);
            end else if (amt_q > LEN_W'(MAX_APPEND)) begin
              res_d = mk_res(ST_BAD_AMT, slot_rec.len);
            end else begin
              newlen_d         = {1'b0, slot_rec.len} + {1'b0, amt_q};
              div_req.start    = 1'b1;
              div_req.dividend = newlen_d;
              pos_phase_d      = 1'b0;
              state_d          = S_DIV;
            end
          end
          default: begin
            res_d = mk_res(ST_BAD_AMT, '0);
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (pos_phase_q) begin
            bi_d    = div_rsp.quot[BIDX_W-1:0];
            off_d   = div_rsp.rem[SIB_W-1:0];
            pos_d   = len_q;
            tok_d   = '0;
            state_d = S_TOK_RD;
          end else if (op_q == OP_TRUNCATE) begin
            keep_d  = (need_full >= (DIV_W+1)'(cnt_q)) ? cnt_q : need_full[CNT_W-1:0];
            idx_d   = keep_d;
            state_d = S_FREE_RD;
          end else if ((newlen_q > DIV_W'(lim_q)) ||
                       (need_full > (DIV_W+1)'(MAX_BLOCKS_PER_SEQ))) begin
            res_d   = mk_res(ST_EXCEEDS, len_q);
            state_d = S_EMIT;
          end else if ((need_full > (DIV_W+1)'(cnt_q)) &&
                       ((need_full - (DIV_W+1)'(cnt_q)) > (DIV_W+1)'(free_top_q))) begin
            res_d   = mk_res(ST_NO_BLOCK, len_q);
            state_d = S_EMIT;
          end else begin
            need_d  = need_full[CNT_W-1:0];
            state_d = S_ALLOC_RD;
          end
        end
      end
      S_FREE_RD: begin
        if (idx_q >= cnt_q) begin
          slot_we = 1'b1;
          state_d = S_EMIT;
          if (op_q == OP_REMOVE) begin
            res_d = mk_res(ST_OK, '0);
          end else begin
            slot_wdata.used = 1'b1;
            slot_wdata.len  = newlen_q[LEN_W-1:0];
            slot_wdata.lim  = lim_q;
            slot_wdata.cnt  = keep_q;
            res_d           = mk_res(ST_OK, newlen_q[LEN_W-1:0]);
          end
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        // push onto a full stack is dropped
        if (free_top_q < TOP_W'(NUM_BLOCKS)) begin
          stk_we     = 1'b1;
          free_top_d = free_top_q + TOP_W'(1);
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_FREE_RD;
      end
      S_ALLOC_RD: begin
        if (cnt_q >= need_q) begin
          slot_we          = 1'b1;
          slot_wdata.used  = 1'b1;
          slot_wdata.len   = newlen_q[LEN_W-1:0];
          slot_wdata.lim   = lim_q;
          slot_wdata.cnt   = cnt_q;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(len_q);
          pos_phase_d      = 1'b1;
          state_d          = S_DIV;
        end else begin
          state_d = S_ALLOC_WR;
        end
      end
      S_ALLOC_WR: begin
        // below the low-water mark the stack still holds its rebuild contents
        tbl_we     = 1'b1;
        tbl_wdata  = (pidx < lw_q) ? BLK_W'(base_q - TOP_W'(1) - pidx) : stk_rdata;
        cnt_d      = cnt_q + CNT_W'(1);
        free_top_d = pidx;
        if (pidx < lw_q) begin
          lw_d = pidx;
        end
        state_d = S_ALLOC_RD;
      end
      S_TOK_RD: begin
        state_d = S_TOK_EM;
      end
      S_TOK_EM: begin
        if (out_free) begin
          m_valid_d      = 1'b1;
          m_res_d        = mk_res(ST_OK, newlen_q[LEN_W-1:0]);
          m_res_d.free   = free_top_q;
          m_res_d.pb     = tbl_rdata;
          m_res_d.sib    = off_q;
          m_res_d.tp     = pos_q[POS_W-1:0];
          m_res_d.last   = (tok_q == tok_last);
          if (({1'b0, off_q} + TPB_W'(1)) == tpb_q) begin
            off_d = '0;
            bi_d  = bi_q + BIDX_W'(1);
          end else begin
            off_d = off_q + SIB_W'(1);
          end
          pos_d   = pos_q + LEN_W'(1);
          tok_d   = tok_q + TOK_W'(1);
          state_d = (tok_q == tok_last) ? S_IDLE : S_TOK_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          m_res_d      = res_q;
          m_res_d.free = free_top_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      cfg_tpb_q  <= TPB_W'(64);
      cfg_pool_q <= TOP_W'(NUM_BLOCKS);
      free_top_q <= TOP_W'(NUM_BLOCKS);
      base_q     <= TOP_W'(NUM_BLOCKS);
      lw_q       <= TOP_W'(NUM_BLOCKS);
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      free_top_q <= free_top_d;
      base_q     <= base_d;
      lw_q       <= lw_d;
      valid_q    <= valid_d;
      if (cfg_valid_i && (cfg_index_i == CFG_TPB)) begin
        cfg_tpb_q <= cfg_data_i[TPB_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == CFG_POOL)) begin
        cfg_pool_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    slot_q      <= slot_d;
    amt_q       <= amt_d;
    tpb_q       <= tpb_d;
    len_q       <= len_d;
    lim_q       <= lim_d;
    cnt_q       <= cnt_d;
    need_q      <= need_d;
    idx_q       <= idx_d;
    keep_q      <= keep_d;
    newlen_q    <= newlen_d;
    bi_q        <= bi_d;
    off_q       <= off_d;
    pos_q       <= pos_d;
    tok_q       <= tok_d;
    pos_phase_q <= pos_phase_d;
    res_q       <= res_d;
    m_res_q     <= m_res_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_res_q.last;
  assign m_axis_tdata  = {1'b0, m_res_q.tp, m_res_q.sib, m_res_q.pb, m_res_q.free,
                          m_res_q.len, m_res_q.status};

endmodule

// File: design/pbtm_checker.sv
// Port-level checks of the paged block table manager, bound to the top level.
`include "paged_block_table_manager_unit_assert.svh"

module pbtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [10:0] cfg_data_i
);

  // stalled result holds
  `PBTM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // one operation at a time: input side closes after an item
  `PBTM_ASSERT_NXT(a_one_op, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // status code in range
  `PBTM_ASSERT_IMP(a_status, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5)
  // only token results of a good append come before the final one
  `PBTM_ASSERT_IMP(a_mid_ok, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[2:0] == 3'd0)
  // free count never exceeds NUM_BLOCKS (1024)
  `PBTM_ASSERT_IMP(a_free, m_axis_tvalid, m_axis_tdata[29:19] <= 11'd1024)

endmodule

bind paged_block_table_manager_unit pbtm_checker u_pbtm_checker (.*);

// File: bench/pbtm_checker.sv
// Result checker for the paged block table manager: tracks config, predicts, compares.
`timescale 1ns / 100ps
module pbtm_scoreboard
  import pbtm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          results_owed_o
);

  typedef struct {
    logic [2:0]       status;
    logic [LEN_W-1:0] len;
    logic [TOP_W-1:0] free;
    logic [BLK_W-1:0] pb;
    logic [SIB_W-1:0] sib;
    logic [POS_W-1:0] tp;
    logic             last;
  } outcome_t;

  outcome_t         owed_q[$];
  logic [BLK_W-1:0] free_stack[NUM_BLOCKS];
  logic [TOP_W-1:0] free_top;
  bit               seq_used[MAX_SEQS];
  logic [LEN_W-1:0] seq_len[MAX_SEQS];
  logic [LEN_W-1:0] seq_lim[MAX_SEQS];
  int               seq_blocks[MAX_SEQS];
  logic [BLK_W-1:0] blk_map[MAX_SEQS*MAX_BLOCKS_PER_SEQ];
  logic [TPB_W-1:0] tpb_reg;
  logic [10:0]      pool_reg;
  int               mismatches;

  assign mismatch_count_o = mismatches;

  task automatic owe(input logic [2:0] st, input int len, input int pb, input int sib,
                     input int tp, input bit lst);
    outcome_t o;
    o.status = st;
    o.len    = len[LEN_W-1:0];
    o.free   = free_top;
    o.pb     = pb[BLK_W-1:0];
    o.sib    = sib[SIB_W-1:0];
    o.tp     = tp[POS_W-1:0];
    o.last   = lst;
    owed_q   = {owed_q, o};
  endtask

  task automatic rebuild_pool();
    int n;
    n = pool_reg;
    if (n > NUM_BLOCKS) n = NUM_BLOCKS;
    for (int i = 0; i < n; i++) free_stack[i] = BLK_W'(n - 1 - i);
    free_top = TOP_W'(n);
    for (int s = 0; s < MAX_SEQS; s++) begin
      seq_used[s]   = 0;
      seq_len[s]    = '0;
      seq_lim[s]    = '0;
      seq_blocks[s] = 0;
    end
    for (int i = 0; i < MAX_SEQS*MAX_BLOCKS_PER_SEQ; i++) blk_map[i] = '0;
  endtask

  // free table entries from keep upward; pushes onto a full stack are lost
  task automatic release_blocks(input int s, input int keep);
    for (int i = keep; i < seq_blocks[s]; i++) begin
      if (free_top < NUM_BLOCKS) begin
        free_stack[free_top] = blk_map[s*MAX_BLOCKS_PER_SEQ + i];
        free_top++;
      end
    end
    if (keep < seq_blocks[s]) seq_blocks[s] = keep;
  endtask

  task automatic predict_op(input logic [2:0] op, input int s, input int amt);
    int t, len, nlen, need, pos;
    t = tpb_reg & 9'h1F0;
    if (t == 0) t = TPB_MIN;
    if (t > TPB_MAX) t = TPB_MAX;
    if (op == OP_REBUILD) begin
      rebuild_pool();
      owe(ST_OK, 0, 0, 0, 0, 1);
    end else if (op > OP_QUERY) begin
      owe(ST_BAD_AMT, 0, 0, 0, 0, 1);
    end else if (op == OP_CREATE) begin
      if (seq_used[s]) owe(ST_EXISTS, seq_len[s], 0, 0, 0, 1);
      else if (amt > MAX_LEN) owe(ST_BAD_AMT, 0, 0, 0, 0, 1);
      else begin
        seq_used[s]   = 1;
        seq_len[s]    = '0;
        seq_lim[s]    = amt[LEN_W-1:0];
        seq_blocks[s] = 0;
        owe(ST_OK, 0, 0, 0, 0, 1);
      end
    end else if (!seq_used[s]) begin
      owe(ST_NOT_FOUND, 0, 0, 0, 0, 1);
    end else begin
      len = seq_len[s];
      case (op)
        OP_REMOVE: begin
          release_blocks(s, 0);
          seq_used[s] = 0;
          seq_len[s]  = '0;
          seq_lim[s]  = '0;
          owe(ST_OK, 0, 0, 0, 0, 1);
        end
        OP_TRUNCATE: begin
          if (amt > len) owe(ST_EXCEEDS, len, 0, 0, 0, 1);
          else begin
            nlen = len - amt;
            release_blocks(s, (nlen + t - 1) / t);
            seq_len[s] = nlen[LEN_W-1:0];
            owe(ST_OK, nlen, 0, 0, 0, 1);
          end
        end
        OP_QUERY: owe(ST_OK, len, 0, 0, 0, 1);
        default: begin
          nlen = len + amt;
          need = (nlen + t - 1) / t;
          if (amt == 0) owe(ST_OK, len, 0, 0, 0, 1);
          else if (amt > MAX_APPEND) owe(ST_BAD_AMT, len, 0, 0, 0, 1);
          else if (nlen > seq_lim[s] || need > MAX_BLOCKS_PER_SEQ)
            owe(ST_EXCEEDS, len, 0, 0, 0, 1);
          else if (need > seq_blocks[s] && need - seq_blocks[s] > free_top)
            owe(ST_NO_BLOCK, len, 0, 0, 0, 1);
          else begin
            while (seq_blocks[s] < need) begin
              free_top--;
              blk_map[s*MAX_BLOCKS_PER_SEQ + seq_blocks[s]] = free_stack[free_top];
              seq_blocks[s]++;
            end
            seq_len[s] = nlen[LEN_W-1:0];
            for (int i = 0; i < amt; i++) begin
              pos = len + i;
              owe(ST_OK, nlen, blk_map[s*MAX_BLOCKS_PER_SEQ + (pos / t) % MAX_BLOCKS_PER_SEQ],
                  pos % t, pos, i + 1 == amt);
            end
          end
        end
      endcase
    end
  endtask

  task automatic compare_result();
    outcome_t exp_o, act;
    act.status = m_axis_tdata[2:0];
    act.len    = m_axis_tdata[18:3];
    act.free   = m_axis_tdata[29:19];
    act.pb     = m_axis_tdata[39:30];
    act.sib    = m_axis_tdata[47:40];
    act.tp     = m_axis_tdata[62:48];
    act.last   = m_axis_tlast;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: tdata=%h last=%b",
                                     m_axis_tdata, m_axis_tlast);
    end else begin
      exp_o = owed_q.pop_front();
      if (exp_o.status !== act.status || exp_o.len !== act.len || exp_o.free !== act.free ||
          exp_o.pb !== act.pb || exp_o.sib !== act.sib || exp_o.tp !== act.tp ||
          exp_o.last !== act.last || m_axis_tdata[63] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp st=%0d len=%0d free=%0d pb=%0d sib=%0d tp=%0d",
                    " last=%0d / got st=%0d len=%0d free=%0d pb=%0d sib=%0d tp=%0d last=%0d"},
                   exp_o.status, exp_o.len, exp_o.free, exp_o.pb, exp_o.sib, exp_o.tp,
                   exp_o.last, act.status, act.len, act.free, act.pb, act.sib, act.tp,
                   act.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_reg    = 9'd64;
      pool_reg   = 11'd1024;
      mismatches = 0;
      owed_q.delete();
      rebuild_pool();
    end else begin
      // drain before predicting so a same-edge result pops an older expectation
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready)
        predict_op(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[21:6]);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TPB) tpb_reg = cfg_data_i[TPB_W-1:0];
        else if (cfg_index_i == CFG_POOL) pool_reg = cfg_data_i;
      end
    end
    results_owed_o = owed_q.size();
  end

endmodule

// File: bench/testbench.sv
// Stimulus, receiver stalls, watchdog and verdict for the paged block table manager.
`timescale 1ns / 100ps
module testbench
  import pbtm_pkg::*;
();

  localparam int STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  int          mismatch_count;
  int          results_owed;
  int          burst_left;
  int          rx_cycle;
  int          quiet_cycles;

  paged_block_table_manager_unit dut (.*);

  pbtm_scoreboard u_checker (
    .*,
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver: the ready pattern steps through four modes in turn
  always @(negedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle >> 6) % 4)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = $urandom_range(0, 1);
      2:       m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = ((rx_cycle % 7) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_op(input logic [2:0] op, input int slot, input int amt);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {2'b00, amt[15:0], slot[5:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic settle_then_write(input logic [1:0] idx, input int value);
    while (results_owed != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value[10:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_op();
    int slot, amt, pick;
    logic [2:0] op;
    slot = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    pick = $urandom_range(0, 99);
    amt  = $urandom_range(0, 65535);
    if (pick < 15) begin
      op = OP_CREATE;
      if ($urandom_range(0, 9) < 7) amt = $urandom_range(0, 2000);
      else if ($urandom_range(0, 1)) amt = MAX_LEN;
    end else if (pick < 52) begin
      op = OP_APPEND;
      if ($urandom_range(0, 9) < 8) amt = $urandom_range(1, MAX_APPEND);
      else if ($urandom_range(0, 1)) amt = 0;
    end else if (pick < 67) begin
      op = OP_TRUNCATE;
      if ($urandom_range(0, 9) < 8) amt = $urandom_range(0, 300);
    end else if (pick < 79) op = OP_REMOVE;
    else if (pick < 93) op = OP_QUERY;
    else if (pick < 96) op = OP_REBUILD;
    else op = $urandom_range(6, 7);
    issue_op(op, slot, amt);
  endtask

  task automatic run_phase(input int tpb, input int pool, input int count);
    settle_then_write(CFG_TPB, tpb);
    settle_then_write(CFG_POOL, pool);
    issue_op(OP_REBUILD, $urandom_range(0, 63), $urandom_range(0, 65535));
    repeat (count) random_op();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    burst_left    = 0;
    rx_cycle      = 0;
    quiet_cycles  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset config: 64 tokens per block, full pool
    issue_op(OP_QUERY, 0, 0);
    issue_op(OP_CREATE, 0, MAX_LEN);
    issue_op(OP_CREATE, 0, 5);
    issue_op(OP_CREATE, 1, 40000);
    issue_op(OP_CREATE, 63, 0);
    issue_op(OP_APPEND, 63, 1);
    issue_op(OP_APPEND, 0, 0);
    issue_op(OP_APPEND, 0, 65);
    issue_op(OP_APPEND, 0, 64);
    issue_op(OP_APPEND, 0, 1);
    issue_op(OP_TRUNCATE, 0, 100);
    issue_op(OP_TRUNCATE, 0, 1);
    issue_op(OP_QUERY, 0, 0);
    issue_op(OP_TRUNCATE, 0, 64);
    issue_op(OP_APPEND, 0, 64);
    issue_op(OP_REMOVE, 0, 0);
    issue_op(OP_REMOVE, 0, 0);
    issue_op(OP_TRUNCATE, 5, 0);
    issue_op(3'd6, 0, 0);
    issue_op(3'd7, 63, 16'hFFFF);
    issue_op(OP_REBUILD, 0, 0);
    issue_op(OP_QUERY, 63, 0);

    run_phase(16, 1, 70);
    run_phase(256, 2047, 70);
    run_phase(0, 0, 50);
    run_phase(100, 40, 70);
    run_phase(511, 8, 70);
    run_phase(64, 1024, 60);

    // fill one sequence to its table size with the smallest blocks
    run_phase(16, 1024, 0);
    issue_op(OP_CREATE, 2, MAX_LEN);
    repeat (34) issue_op(OP_APPEND, 2, MAX_APPEND);
    issue_op(OP_TRUNCATE, 2, 1000);
    issue_op(OP_REMOVE, 2, 0);
    issue_op(OP_QUERY, 2, 0);

    while (results_owed != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
